// ----- rtl/ssrs_pkg.sv -----
// Shared types, constants and helpers of the strip solid-run splitter.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package ssrs_pkg;

  localparam int unsigned STRIP_ROWS     = 16;
  localparam int unsigned MAX_FRAME_SIDE = 4096;

  localparam int unsigned SIDE_W   = $clog2(MAX_FRAME_SIDE) + 1;  // holds 1..MAX_FRAME_SIDE
  localparam int unsigned X_W      = $clog2(MAX_FRAME_SIDE);      // column / row positions
  localparam int unsigned ROW_W    = (STRIP_ROWS > 1) ? $clog2(STRIP_ROWS) : 1;
  localparam int unsigned ROWS_W   = $clog2(STRIP_ROWS + 1);
  localparam int unsigned HEIGHT_W = 5;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned PIX_W    = 4 * CHAN_W;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_SOLID_LIMIT  = 2'd2,
    REG_DRAW_SOLID   = 2'd3
  } reg_idx_e;

  typedef enum logic {
    CMD_IMAGE = 1'b0,
    CMD_SOLID = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    logic [SIDE_W-1:0] frame_width;
    logic [SIDE_W-1:0] frame_height;
    logic [SIDE_W-1:0] solid_limit;
    logic              draw_solid;
  } cfg_t;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [X_W-1:0]      left_x;
    logic [X_W-1:0]      top_y;
    logic [SIDE_W-1:0]   span_width;
    logic [HEIGHT_W-1:0] span_height;
    logic [CHAN_W-1:0]   fill_red;
    logic [CHAN_W-1:0]   fill_green;
    logic [CHAN_W-1:0]   fill_blue;
    logic                last;
  } cmd_t;

  // 0 acts as 1, anything above the largest side acts as the largest side
  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    if (v == '0) begin
      r = SIDE_W'(1);
    end else if (v > SIDE_W'(MAX_FRAME_SIDE)) begin
      r = SIDE_W'(MAX_FRAME_SIDE);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic cmd_t mk_cmd(input cmd_kind_e         kind,
                                  input logic [X_W-1:0]    left,
                                  input logic [X_W-1:0]    top,
                                  input logic [SIDE_W-1:0] width,
                                  input logic [ROWS_W-1:0] rows,
                                  input logic [PIX_W-1:0]  color);
    cmd_t c;
    c.kind        = kind;
    c.left_x      = left;
    c.top_y       = top;
    c.span_width  = width;
    c.span_height = HEIGHT_W'(rows);
    c.fill_red    = (kind == CMD_SOLID) ? color[4*CHAN_W-1:3*CHAN_W] : '0;
    c.fill_green  = (kind == CMD_SOLID) ? color[3*CHAN_W-1:2*CHAN_W] : '0;
    c.fill_blue   = (kind == CMD_SOLID) ? color[2*CHAN_W-1:CHAN_W]   : '0;
    c.last        = 1'b0;
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ssrs_engine.sv -----
// Column, run and span tracking: turns one registered pixel into up to three commands.
// Depends on ssrs_pkg.
`default_nettype none

module ssrs_engine import ssrs_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [PIX_W-1:0] pix_i,
  input  wire cfg_t             cfg_i,
  output logic [1:0]            n_o,
  output cmd_t                  cmd0_o,
  output cmd_t                  cmd1_o,
  output cmd_t                  cmd2_o
);

  logic [PIX_W-1:0]  top_q, top_d;
  logic              uni_q, uni_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [X_W-1:0]    col_q, col_d;
  logic [X_W-1:0]    strip_q, strip_d;
  logic [PIX_W-1:0]  rcol_q, rcol_d;
  logic [X_W-1:0]    rstart_q, rstart_d;
  logic [SIDE_W-1:0] rlen_q, rlen_d;
  logic [X_W-1:0]    sstart_q, sstart_d;
  logic [SIDE_W-1:0] send_q, send_d;
  logic              spend_q, spend_d;

  logic [SIDE_W-1:0] width, height, diff, strip_sum;
  logic [ROWS_W-1:0] rows;
  logic [SIDE_W:0]   lim_p1;
  logic              col_end, last_col, extend;
  logic [1:0]        n;
  cmd_t              c0, c1, c2, nc;

  assign width  = clamp_side(cfg_i.frame_width);
  assign height = clamp_side(cfg_i.frame_height);
  assign lim_p1 = {1'b0, cfg_i.solid_limit} + (SIDE_W+1)'(1);

  // rows in the current strip; a strip at or below the frame bottom has one row
  always_comb begin
    diff = height - SIDE_W'(strip_q);
    if (height > SIDE_W'(strip_q)) begin
      rows = (diff > SIDE_W'(STRIP_ROWS)) ? ROWS_W'(STRIP_ROWS) : diff[ROWS_W-1:0];
    end else begin
      rows = ROWS_W'(1);
    end
  end

  always_comb begin
    top_d    = top_q;
    uni_d    = uni_q;
    row_d    = row_q;
    col_d    = col_q;
    strip_d  = strip_q;
    rcol_d   = rcol_q;
    rstart_d = rstart_q;
    rlen_d   = rlen_q;
    sstart_d = sstart_q;
    send_d   = send_q;
    spend_d  = spend_q;
    n        = 2'd0;
    c0       = '0;
    c1       = '0;
    c2       = '0;
    nc       = '0;
    extend   = 1'b0;
    strip_sum = SIDE_W'(strip_q) + SIDE_W'(rows);
    last_col = (SIDE_W'(col_q) + SIDE_W'(1)) >= width;
    col_end  = (ROWS_W'(row_q) + ROWS_W'(1)) >= rows;

    if (row_q == '0) begin
      top_d = pix_i;
      uni_d = 1'b1;
    end else if (pix_i != top_q) begin
      uni_d = 1'b0;
    end

    if (!col_end) begin
      row_d = row_q + ROW_W'(1);
    end else begin
      row_d  = '0;
      extend = uni_d && (rlen_q != '0) && (top_d == rcol_q);
      if (extend) begin
        rlen_d = rlen_q + SIDE_W'(1);
        // run just got wide enough to go solid: the span before it goes out now
        if (({1'b0, rlen_d} == lim_p1) && spend_d) begin
          nc = mk_cmd(CMD_IMAGE, sstart_d, strip_q, send_d - SIDE_W'(sstart_d), rows, '0);
          if (n == 2'd0) c0 = nc; else if (n == 2'd1) c1 = nc; else c2 = nc;
          n = n + 2'd1;
          spend_d = 1'b0;
        end
      end else begin
        if (rlen_q != '0) begin
          if (rlen_q > cfg_i.solid_limit) begin
            if (cfg_i.draw_solid) begin
              nc = mk_cmd(CMD_SOLID, rstart_q, strip_q, rlen_q, rows, rcol_q);
              if (n == 2'd0) c0 = nc; else if (n == 2'd1) c1 = nc; else c2 = nc;
              n = n + 2'd1;
            end
          end else begin
            if (!spend_d) begin
              sstart_d = rstart_q;
              spend_d  = 1'b1;
            end
            send_d = SIDE_W'(rstart_q) + rlen_q;
          end
        end
        rlen_d = '0;
        if (uni_d) begin
          rcol_d   = top_d;
          rstart_d = col_q;
          rlen_d   = SIDE_W'(1);
          if ((lim_p1 == (SIDE_W+1)'(1)) && spend_d) begin
            nc = mk_cmd(CMD_IMAGE, sstart_d, strip_q, send_d - SIDE_W'(sstart_d), rows, '0);
            if (n == 2'd0) c0 = nc; else if (n == 2'd1) c1 = nc; else c2 = nc;
            n = n + 2'd1;
            spend_d = 1'b0;
          end
        end else begin
          if (!spend_d) begin
            sstart_d = col_q;
            spend_d  = 1'b1;
          end
          send_d = SIDE_W'(col_q) + SIDE_W'(1);
        end
      end

      if (last_col) begin
        if (rlen_d != '0) begin
          if (rlen_d > cfg_i.solid_limit) begin
            if (cfg_i.draw_solid) begin
              nc = mk_cmd(CMD_SOLID, rstart_d, strip_q, rlen_d, rows, rcol_d);
              if (n == 2'd0) c0 = nc; else if (n == 2'd1) c1 = nc; else c2 = nc;
              n = n + 2'd1;
            end
          end else begin
            if (!spend_d) begin
              sstart_d = rstart_d;
              spend_d  = 1'b1;
            end
            send_d = SIDE_W'(rstart_d) + rlen_d;
          end
        end
        rlen_d = '0;
        if (spend_d) begin
          nc = mk_cmd(CMD_IMAGE, sstart_d, strip_q, send_d - SIDE_W'(sstart_d), rows, '0);
          if (n == 2'd0) c0 = nc; else if (n == 2'd1) c1 = nc; else c2 = nc;
          n = n + 2'd1;
          spend_d = 1'b0;
        end
        col_d   = '0;
        strip_d = (strip_sum >= height) ? '0 : strip_sum[X_W-1:0];
      end else begin
        col_d = col_q + X_W'(1);
      end
    end

    if (n == 2'd1) c0.last = 1'b1;
    if (n == 2'd2) c1.last = 1'b1;
    if (n == 2'd3) c2.last = 1'b1;
  end

  assign n_o    = n;
  assign cmd0_o = c0;
  assign cmd1_o = c1;
  assign cmd2_o = c2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q    <= '0;
      uni_q    <= 1'b1;
      row_q    <= '0;
      col_q    <= '0;
      strip_q  <= '0;
      rcol_q   <= '0;
      rstart_q <= '0;
      rlen_q   <= '0;
      sstart_q <= '0;
      send_q   <= '0;
      spend_q  <= 1'b0;
    end else if (step_i) begin
      top_q    <= top_d;
      uni_q    <= uni_d;
      row_q    <= row_d;
      col_q    <= col_d;
      strip_q  <= strip_d;
      rcol_q   <= rcol_d;
      rstart_q <= rstart_d;
      rlen_q   <= rlen_d;
      sstart_q <= sstart_d;
      send_q   <= send_d;
      spend_q  <= spend_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ssrs_cmd_buf.sv -----
// Three-entry command register that drains one command per transaction on the output.
// Depends on ssrs_pkg.
`default_nettype none

module ssrs_cmd_buf import ssrs_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       load_i,
  input  wire logic [1:0] n_i,
  input  wire cmd_t       c0_i,
  input  wire cmd_t       c1_i,
  input  wire cmd_t       c2_i,
  input  wire logic       out_ready_i,
  output logic            out_valid_o,
  output cmd_t            head_o,
  output logic            free_o
);

  logic [1:0] cnt_q, cnt_d;
  cmd_t       s0_q, s0_d, s1_q, s1_d, s2_q, s2_d;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign head_o      = s0_q;
  assign pop         = out_valid_o && out_ready_i;
  // empty, or the last entry leaves in this cycle
  assign free_o      = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);

  always_comb begin
    cnt_d = cnt_q;
    s0_d  = s0_q;
    s1_d  = s1_q;
    s2_d  = s2_q;
    if (load_i) begin
      cnt_d = n_i;
      s0_d  = c0_i;
      s1_d  = c1_i;
      s2_d  = c2_i;
    end else if (pop) begin
      cnt_d = cnt_q - 2'd1;
      s0_d  = s1_q;
      s1_d  = s2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
    s1_q <= s1_d;
    s2_q <= s2_d;
  end

`ifndef SYNTHESIS
  a_triple_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd3) |-> (!s0_q.last && !s1_q.last && s2_q.last))
    else $error("triple end mark wrong");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i)))
    else $error("load while commands still pending");
  a_load_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (n_i != 2'd0)) else $error("bad command count on load");
  a_pair_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> (!s0_q.last && s1_q.last)) else $error("pair end mark wrong");
  a_single_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> s0_q.last) else $error("single command lacks end mark");
`endif

endmodule

`default_nettype wire

// ----- rtl/strip_solid_run_splitter.sv -----
// Strip solid-run splitter: pixels in, draw-image and solid-rectangle commands out.
// Depends on ssrs_pkg, ssrs_engine and ssrs_cmd_buf.
//
// Pixels enter one per clock while in_ready_o is high: each accepted pixel is held
// in an input register and processed once the result register can take its commands,
// which (zero to three) land in that three-entry result register. The output drains
// one command per cycle while out_ready_i is high; after a pixel that yields two or
// three commands, the next pixel that yields commands waits until the last of them
// leaves; otherwise, with out_ready_i high, the sustained rate is one pixel per clock.
// Three commands only come from a pixel after the solid limit was lowered mid-frame.
// Configuration writes are always accepted and should be issued only while no
// pixel is in flight.
`default_nettype none

module strip_solid_run_splitter import ssrs_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [CHAN_W-1:0]    red_i,
  input  wire logic [CHAN_W-1:0]    green_i,
  input  wire logic [CHAN_W-1:0]    blue_i,
  input  wire logic [CHAN_W-1:0]    alpha_i,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [SIDE_W-1:0]    cfg_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      command_kind_o,
  output logic [X_W-1:0]            left_x_o,
  output logic [X_W-1:0]            top_y_o,
  output logic [SIDE_W-1:0]         span_width_o,
  output logic [HEIGHT_W-1:0]       span_height_o,
  output logic [CHAN_W-1:0]         fill_red_o,
  output logic [CHAN_W-1:0]         fill_green_o,
  output logic [CHAN_W-1:0]         fill_blue_o,
  output logic                      last_of_step_o
);

  cfg_t             cfg_q;
  logic [PIX_W-1:0] pix_q;
  logic             pix_vld_q;
  logic [1:0]       n;
  cmd_t             c0, c1, c2, head;
  logic             free, fire, load;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= SIDE_W'(640);
      cfg_q.frame_height <= SIDE_W'(480);
      cfg_q.solid_limit  <= SIDE_W'(16);
      cfg_q.draw_solid   <= 1'b1;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data_i;
        REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data_i;
        REG_SOLID_LIMIT:  cfg_q.solid_limit  <= cfg_data_i;
        REG_DRAW_SOLID:   cfg_q.draw_solid   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // a pixel with no commands never waits on the result register
  assign fire       = pix_vld_q && ((n == 2'd0) || free);
  assign load       = fire && (n != 2'd0);
  assign in_ready_o = !pix_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      pix_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      pix_q <= {red_i, green_i, blue_i, alpha_i};
    end
  end

  ssrs_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (fire),
    .pix_i  (pix_q),
    .cfg_i  (cfg_q),
    .n_o    (n),
    .cmd0_o (c0),
    .cmd1_o (c1),
    .cmd2_o (c2)
  );

  ssrs_cmd_buf u_cmd_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .n_i         (n),
    .c0_i        (c0),
    .c1_i        (c1),
    .c2_i        (c2),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .head_o      (head),
    .free_o      (free)
  );

  assign command_kind_o = head.kind;
  assign left_x_o       = head.left_x;
  assign top_y_o        = head.top_y;
  assign span_width_o   = head.span_width;
  assign span_height_o  = head.span_height;
  assign fill_red_o     = head.fill_red;
  assign fill_green_o   = head.fill_green;
  assign fill_blue_o    = head.fill_blue;
  assign last_of_step_o = head.last;

endmodule

`default_nettype wire
